// ===== rtl/srt_pkg.sv =====
// Shared types and codes for the sorted region table.
package srt_pkg;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [47:0] base_address;
    logic [47:0] range_length;
    logic [1:0]  region_kind;
    logic [5:0]  node_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  entry_count_out;
    logic [48:0] covered_total_out;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic piece_a;
    logic piece_b;
    logic tail;
    logic flush;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
  } sts_t;

endpackage

// ===== rtl/srt_ctrl.sv =====
// Sequencer that walks the table entries for one request.
module srt_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  srt_pkg::sts_t sts,
  output logic         busy,
  output srt_pkg::cmd_t cmd
);
  import srt_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RD    = 8'b0000_0010,
    S_PA    = 8'b0000_0100,
    S_PB    = 8'b0000_1000,
    S_TAIL  = 8'b0001_0000,
    S_DRAIN = 8'b0010_0000,
    S_FLUSH = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = sts.empty ? S_TAIL : S_RD;
      S_RD:    state_next = S_PA;
      S_PA:    state_next = S_PB;
      S_PB:    state_next = sts.last ? S_TAIL : S_RD;
      S_TAIL:  state_next = S_DRAIN;
      S_DRAIN: state_next = S_FLUSH;
      S_FLUSH: state_next = S_FIN;
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy        = (state != S_IDLE);
  assign cmd.load    = (state == S_IDLE) && start;
  assign cmd.piece_a = (state == S_PA);
  assign cmd.piece_b = (state == S_PB);
  assign cmd.tail    = (state == S_TAIL);
  assign cmd.flush   = (state == S_FLUSH);
  assign cmd.finish  = (state == S_FIN);

endmodule

// ===== rtl/srt_dp.sv =====
// Datapath: two table banks, piece generation, merge stage and totals.
module srt_dp #(
  parameter int TABLE_DEPTH = 64,
  parameter int ADDR_BITS   = 48,
  parameter int NODE_BITS   = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  srt_pkg::req_t req,
  input  srt_pkg::cmd_t cmd,
  output srt_pkg::sts_t sts,
  output logic          done,
  output srt_pkg::rsp_t rsp
);
  import srt_pkg::*;

  localparam int A  = ADDR_BITS;
  localparam int N  = NODE_BITS;
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int WW = $clog2(2 * TABLE_DEPTH + 3);
  localparam int EW = 2 * A + 2 + N;
  localparam logic [A:0] TOP = {1'b1, {A{1'b0}}};

  logic [EW-1:0] mem [0:2*(2**IW)-1];

  logic          bank;
  logic [CW-1:0] count;
  logic [A:0]    total;
  logic          op;
  logic [A-1:0]  base;
  logic [A:0]    endv;
  logic [1:0]    kind;
  logic [N-1:0]  node;
  logic [A:0]    cur;
  logic [IW-1:0] idx;
  logic          hit;
  logic [EW-1:0] rd_q;

  logic          q_valid;
  logic [A-1:0]  q_s, q_l;
  logic [1:0]    q_k;
  logic [N-1:0]  q_n;
  logic          p_valid;
  logic [A-1:0]  p_s, p_l;
  logic [1:0]    p_k;
  logic [N-1:0]  p_n;
  logic [WW-1:0] w;
  logic [A:0]    sum;
  logic [1:0]    status_q;

  logic [A-1:0]  e_s, e_l;
  logic [1:0]    e_k;
  logic [N-1:0]  e_n;
  logic [A:0]    rs, re, stop, in_end, req_base, req_len;
  logic          ovl;

  logic          emit;
  logic [A-1:0]  es, el;
  logic [1:0]    ek;
  logic [N-1:0]  en;

  logic [A:0]    p_end, len_sum;
  logic          mergeable, wr_en, full, empty_add, commit;
  logic [63:0]   cnt_ext, tot_ext;

  assign e_s = rd_q[A-1:0];
  assign e_l = rd_q[2*A-1:A];
  assign e_k = rd_q[2*A+1:2*A];
  assign e_n = rd_q[EW-1:2*A+2];
  assign rs  = {1'b0, e_s};
  assign re  = rs + {1'b0, e_l};
  assign ovl = !(re <= {1'b0, base} || rs >= endv || e_l == '0);
  assign stop = (rs < endv) ? rs : endv;

  assign req_base = {1'b0, req.base_address[A-1:0]};
  assign req_len  = {1'b0, req.range_length[A-1:0]};
  assign in_end   = req_base + req_len;

  // Pieces produced by the current step, in table order.
  always_comb begin
    emit = 1'b0;
    es   = e_s;
    el   = e_l;
    ek   = e_k;
    en   = e_n;
    if (cmd.piece_a) begin
      if (op == OP_ADD) begin
        if (rs > cur && cur < endv) begin
          emit = 1'b1;
          es   = cur[A-1:0];
          el   = A'(stop - cur);
          ek   = kind;
          en   = node;
        end
      end else if (!ovl) begin
        emit = 1'b1;
      end else if (e_s < base) begin
        emit = 1'b1;
        el   = base - e_s;
      end
    end else if (cmd.piece_b) begin
      if (op == OP_ADD) begin
        emit = 1'b1;
      end else if (ovl && re > endv) begin
        emit = 1'b1;
        es   = endv[A-1:0];
        el   = A'(re - endv);
      end
    end else if (cmd.tail) begin
      if (op == OP_ADD && cur < endv) begin
        emit = 1'b1;
        es   = cur[A-1:0];
        el   = A'(endv - cur);
        ek   = kind;
        en   = node;
      end
    end
  end

  assign p_end     = {1'b0, p_s} + {1'b0, p_l};
  assign len_sum   = {1'b0, p_l} + {1'b0, q_l};
  assign mergeable = (op == OP_ADD) && p_valid && (p_end == {1'b0, q_s}) &&
                     (p_k == q_k) && (p_n == q_n) && !len_sum[A];
  assign wr_en     = p_valid && ((q_valid && !mergeable) || cmd.flush);
  assign full      = (w > WW'(TABLE_DEPTH));
  assign empty_add = (op == OP_ADD) && (endv <= {1'b0, base});
  assign commit    = !full && ((op == OP_ADD && !empty_add) ||
                               (op == OP_REMOVE && hit));

  always_ff @(posedge clk) begin
    rd_q <= mem[{bank, idx}];
    if (wr_en && w < WW'(TABLE_DEPTH)) begin
      mem[{~bank, w[IW-1:0]}] <= {p_n, p_k, p_l, p_s};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank     <= 1'b0;
      count    <= '0;
      total    <= '0;
      q_valid  <= 1'b0;
      p_valid  <= 1'b0;
      done     <= 1'b0;
      status_q <= ST_OK;
    end else begin
      done    <= cmd.finish;
      q_valid <= emit;
      if (emit) begin
        q_s <= es;
        q_l <= el;
        q_k <= ek;
        q_n <= en;
      end
      if (cmd.load) begin
        op      <= req.operation;
        base    <= req_base[A-1:0];
        endv    <= in_end[A] ? TOP : in_end;
        kind    <= req.region_kind;
        node    <= req.node_id[N-1:0];
        cur     <= req_base;
        idx     <= '0;
        hit     <= 1'b0;
        w       <= '0;
        sum     <= '0;
        p_valid <= 1'b0;
      end
      if (cmd.piece_a && op == OP_REMOVE && ovl) hit <= 1'b1;
      if (cmd.piece_b) begin
        idx <= idx + 1'b1;
        if (op == OP_ADD && re > cur) cur <= re;
      end
      if (wr_en) begin
        w   <= w + 1'b1;
        sum <= sum + {1'b0, p_l};
      end
      if (q_valid) begin
        if (mergeable) begin
          p_l <= len_sum[A-1:0];
        end else begin
          p_valid <= 1'b1;
          p_s     <= q_s;
          p_l     <= q_l;
          p_k     <= q_k;
          p_n     <= q_n;
        end
      end else if (cmd.flush) begin
        p_valid <= 1'b0;
      end
      if (cmd.finish) begin
        if (op == OP_REMOVE && !hit) status_q <= ST_INVALID;
        else if (empty_add) status_q <= ST_OK;
        else if (full) status_q <= ST_FULL;
        else status_q <= ST_OK;
        if (commit) begin
          bank  <= ~bank;
          count <= CW'(w);
          total <= sum;
        end
      end
    end
  end

  assign sts.empty = (count == '0);
  assign sts.last  = ((CW'(idx) + 1'b1) == count);

  assign cnt_ext = 64'(count);
  assign tot_ext = 64'(total);
  assign rsp.status            = status_q;
  assign rsp.entry_count_out   = cnt_ext[6:0];
  assign rsp.covered_total_out = tot_ext[48:0];

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH)) else $error("entry count above table depth");
  a_flush_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |-> !q_valid) else $error("flush with a piece still in flight");
  a_done_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status == ST_OK || rsp.status == ST_INVALID ||
              rsp.status == ST_FULL)) else $error("bad status code");

endmodule

// ===== rtl/sorted_region_table_add_remove_top.sv =====
// Top level of the sorted region table with add and remove requests.
// A request walks every stored entry through the read and the two piece steps, then
// passes the tail piece, the merge drain, the flush and the result; one request
// is in work at a time.
// The result is shown on rsp for one cycle with done high; the receiver cannot stall.
// Synchronous reset empties the table; entry contents stay undefined until written.
module sorted_region_table_add_remove_top #(
  parameter int TABLE_DEPTH = 64,
  parameter int ADDR_BITS   = 48,
  parameter int NODE_BITS   = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  srt_pkg::req_t req,
  output logic          done,
  output srt_pkg::rsp_t rsp
);
  import srt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  srt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  srt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_BITS   (ADDR_BITS),
    .NODE_BITS   (NODE_BITS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .sts  (sts),
    .done (done),
    .rsp  (rsp)
  );

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without a request in work");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("still busy when the result is shown");

endmodule
